[hdl/lps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared constants, codes and types for the line pixel stepper
package lps_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int Q_DEPTH        = 2;

    // request kinds carried on tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // per-axis step direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } lps_q_stat_t;

    // queue entry: start flag, xs, ys, adx, ady, dir_x, dir_y, major, color
    function automatic int lps_entry_bits(input int cb);
        return 5 * cb + 21;
    endfunction

endpackage
`default_nettype wire

[hdl/lps_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// front end: takes requests, works out deltas, directions and major length
module lps_front
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [((4*COORD_BITS+16+7)/8)*8-1:0]      s_tdata,
    input  wire logic                                      s_tuser,
    input  wire lps_q_stat_t                               q_stat,
    output logic                                           push,
    output logic [lps_entry_bits(COORD_BITS)-1:0]          push_entry
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] xs, ys, xe, ye;
    logic [15:0]   color;
    logic [CB-1:0] adx, ady, major;
    logic [1:0]    dirx, diry;
    logic          is_start;

    always_comb
    begin
        xs    = s_tdata[CB-1:0];
        ys    = s_tdata[2*CB-1:CB];
        xe    = s_tdata[3*CB-1:2*CB];
        ye    = s_tdata[4*CB-1:3*CB];
        color = s_tdata[4*CB+15:4*CB];
        is_start = (s_tuser == CMD_START);

        if (xe > xs)
        begin
            adx  = xe - xs;
            dirx = DIR_PLUS;
        end
        else if (xe < xs)
        begin
            adx  = xs - xe;
            dirx = DIR_MINUS;
        end
        else
        begin
            adx  = '0;
            dirx = DIR_NONE;
        end

        if (ye > ys)
        begin
            ady  = ye - ys;
            diry = DIR_PLUS;
        end
        else if (ye < ys)
        begin
            ady  = ys - ye;
            diry = DIR_MINUS;
        end
        else
        begin
            ady  = '0;
            diry = DIR_NONE;
        end

        major = (adx > ady) ? adx : ady;

        s_tready   = !q_stat.full;
        push       = s_tvalid && !q_stat.full;
        push_entry = {color, major, diry, dirx, ady, adx, ys, xs, is_start};
    end

endmodule
`default_nettype wire

[hdl/lps_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// short queue of classified requests between front and back
module lps_queue
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    input  wire logic [lps_entry_bits(COORD_BITS)-1:0] push_entry,
    input  wire logic                                  pop,
    output logic [lps_entry_bits(COORD_BITS)-1:0]      pop_entry,
    output lps_q_stat_t                                q_stat
);

    localparam int EB        = lps_entry_bits(COORD_BITS);
    localparam int PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(Q_DEPTH + 1);

    logic [EB-1:0]       slot_reg [Q_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        q_stat.full  = (count_reg == CNT_BITS'(Q_DEPTH));
        q_stat.empty = (count_reg == '0);
        pop_entry    = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

[hdl/lps_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// back end: holds the running line, steps it and drives the pixel register
module lps_back
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lps_q_stat_t                           q_stat,
    input  wire logic [lps_entry_bits(COORD_BITS)-1:0] pop_entry,
    output logic                                       pop,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [COORD_BITS-1:0]                      out_x,
    output logic [COORD_BITS-1:0]                      out_y,
    output logic [15:0]                                out_color,
    output logic                                       out_last,
    output logic                                       line_active
);

    localparam int CB = COORD_BITS;

    // line state
    logic          active_reg, active_next;
    logic [CB-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CB:0]   err_x_reg, err_x_next, err_y_reg, err_y_next;
    logic [CB-1:0] adx_reg, adx_next, ady_reg, ady_next;
    logic [1:0]    dirx_reg, dirx_next, diry_reg, diry_next;
    logic [CB-1:0] major_reg, major_next, left_reg, left_next;
    logic [15:0]   color_reg, color_next;

    // pixel output register
    logic          ovalid_reg, ovalid_next;
    logic [CB-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [15:0]   ocolor_reg, ocolor_next;
    logic          olast_reg, olast_next;

    // base values: fresh line from the queue or the running one
    logic          e_start, emit, last;
    logic [CB-1:0] b_x, b_y, b_adx, b_ady, b_major, b_left;
    logic [CB:0]   b_err_x, b_err_y;
    logic [1:0]    b_dirx, b_diry;
    logic [15:0]   b_color;
    logic [2*CB:0] adv_x, adv_y;

    // one Bresenham step on one axis, returns {err, pos}
    function automatic logic [2*CB:0] axis_step(
        input logic [CB-1:0] pos,
        input logic [CB:0]   err,
        input logic [CB-1:0] mag,
        input logic [1:0]    dir,
        input logic [CB-1:0] major
    );
        logic [CB:0]   sum;
        logic [CB-1:0] npos;
        logic [CB:0]   nerr;
        sum  = err + {1'b0, mag};
        npos = pos;
        nerr = sum;
        if (sum > {1'b0, major})
        begin
            nerr = sum - {1'b0, major};
            case (dir)
                DIR_PLUS:  npos = pos + 1'b1;
                DIR_MINUS: npos = pos - 1'b1;
                default:   npos = pos;
            endcase
        end
        return {nerr, npos};
    endfunction

    always_comb
    begin
        pop     = !q_stat.empty && (!ovalid_reg || out_ready);
        e_start = (pop_entry[0] == 1'b1);

        b_x     = e_start ? pop_entry[CB:1]             : cur_x_reg;
        b_y     = e_start ? pop_entry[2*CB:CB+1]        : cur_y_reg;
        b_adx   = e_start ? pop_entry[3*CB:2*CB+1]      : adx_reg;
        b_ady   = e_start ? pop_entry[4*CB:3*CB+1]      : ady_reg;
        b_dirx  = e_start ? pop_entry[4*CB+2:4*CB+1]    : dirx_reg;
        b_diry  = e_start ? pop_entry[4*CB+4:4*CB+3]    : diry_reg;
        b_major = e_start ? pop_entry[5*CB+4:4*CB+5]    : major_reg;
        b_color = e_start ? pop_entry[5*CB+20:5*CB+5]   : color_reg;
        b_left  = e_start ? pop_entry[5*CB+4:4*CB+5]    : left_reg;
        b_err_x = e_start ? {1'b0, pop_entry[3*CB:2*CB+1]} : err_x_reg;
        b_err_y = e_start ? {1'b0, pop_entry[4*CB:3*CB+1]} : err_y_reg;

        // a step request with no line running is dropped
        emit = pop && (e_start || active_reg);
        last = (b_left == '0);

        adv_x = axis_step(b_x, b_err_x, b_adx, b_dirx, b_major);
        adv_y = axis_step(b_y, b_err_y, b_ady, b_diry, b_major);

        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_x_next  = err_x_reg;
        err_y_next  = err_y_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        dirx_next   = dirx_reg;
        diry_next   = diry_reg;
        major_next  = major_reg;
        left_next   = left_reg;
        color_next  = color_reg;

        ovalid_next = ovalid_reg && !out_ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;
        olast_next  = olast_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            ox_next     = b_x;
            oy_next     = b_y;
            ocolor_next = b_color;
            olast_next  = last;

            active_next = !last;
            adx_next    = b_adx;
            ady_next    = b_ady;
            dirx_next   = b_dirx;
            diry_next   = b_diry;
            major_next  = b_major;
            color_next  = b_color;
            if (!last)
            begin
                left_next  = b_left - 1'b1;
                cur_x_next = adv_x[CB-1:0];
                err_x_next = adv_x[2*CB:CB];
                cur_y_next = adv_y[CB-1:0];
                err_y_next = adv_y[2*CB:CB];
            end
        end

        out_valid   = ovalid_reg;
        out_x       = ox_reg;
        out_y       = oy_reg;
        out_color   = ocolor_reg;
        out_last    = olast_reg;
        line_active = active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        err_x_reg  <= err_x_next;
        err_y_reg  <= err_y_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        dirx_reg   <= dirx_next;
        diry_reg   <= diry_next;
        major_reg  <= major_next;
        left_reg   <= left_next;
        color_reg  <= color_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocolor_reg <= ocolor_next;
        olast_reg  <= olast_next;
    end

endmodule
`default_nettype wire

[hdl/line_pixel_stepper_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// top level of the line pixel stepper: front, request queue and back
//
//   channel  dir  handshake             tdata / tuser
//   s_*      in   s_tvalid / s_tready   x_start, y_start, x_end, y_end, line_color / cmd
//   m_*      out  m_tvalid / m_tready   pixel_x, pixel_y, pixel_color / tlast = last_pixel
//
// one request per cycle sustained while m_tready is high, one pixel per cycle out; a request is
// written into the queue at the taking edge, and the back end pops it into the output register for
// m_* and advances the running line with the add-compare step per axis.
// reset clears the queue, the line-active flag and the output valid; no sweep.
// a stalled m_tready holds the pixel register; the queue then fills and s_tready drops.
module line_pixel_stepper_top
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // x_start, y_start, x_end, y_end, line_color, zero pad
    input  wire logic [((4*COORD_BITS+16+7)/8)*8-1:0]  s_tdata,
    // cmd
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+16+7)/8)*8-1:0]       m_tdata,
    output logic                                       m_tlast
);

    localparam int EB    = lps_entry_bits(COORD_BITS);
    localparam int OUT_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8;

    lps_q_stat_t            q_stat;
    logic                   push, pop, line_active;
    logic [EB-1:0]          push_entry, pop_entry;
    logic [COORD_BITS-1:0]  px, py;
    logic [15:0]            pcolor;

    lps_front #(.COORD_BITS(COORD_BITS)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    lps_queue #(.COORD_BITS(COORD_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    lps_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_x       (px),
        .out_y       (py),
        .out_color   (pcolor),
        .out_last    (m_tlast),
        .line_active (line_active)
    );

    assign m_tdata = OUT_W'({pcolor, py, px});

    // a shown pixel is the last one exactly when no line is left running
    a_last_vs_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == !line_active))
        else $error("last flag disagrees with line state");

    // a taken request is in the queue at the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !q_stat.empty)
        else $error("accepted request missing from queue");

    // nothing is popped from an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
